>>> hdl/fbt_pkg.sv
// Shared types, codes and constants of the flow border tagger.
package fbt_pkg;

    localparam int unsigned NUM_DEVICES_DEF = 16;
    localparam int unsigned NUM_IFACES_DEF  = 1024;

    localparam int unsigned DEV_W   = 8;
    localparam int unsigned IF_W    = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned CFG_W   = 32;

    localparam logic [TIME_W-1:0]  INTERVAL_RESET = 32'd300;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX       = '1;

    typedef enum logic [1:0] {
        OP_FLOW  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic {
        KIND_FLOW   = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        TAG_UNKNOWN = 2'd0,
        TAG_IN      = 2'd1,
        TAG_OUT     = 2'd2
    } tag_t;

    typedef enum logic {
        CFG_DROP_UNKNOWN = 1'b0,
        CFG_INTERVAL     = 1'b1
    } cfg_index_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_item;
        logic tbl_write;
        logic clr_write;
        logic rd_out;
        logic cap_in_mark;
        logic cap_out_mark;
        logic div_start;
        logic win_restart;
        logic load_report;
        logic load_flow;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic roll_due;
        logic window_begun;
        logic div_busy;
        logic clr_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

>>> hdl/flow_border_tagger.sv
// Top level of the flow border tagger: controller, datapath and configuration port.
//
// Items enter on the input channel (in_valid/in_ready) as flow records, table entry
// writes or whole-table clears. Each flow record yields one tagged flow result on the
// output channel (out_valid/out_ready), preceded by a window report when the flow
// starts past the current window boundary and the window had begun; last marks the
// final result of an item. Table writes and clears yield no result.
// A flow record passes through states S_LOOK_IN, S_LOOK_OUT, S_CHECK and S_FLOW, and the
// next item is taken once its result is loaded; the flow path is limited by the two
// sequential reads of the single read port of the mark table. A window rollover
// adds state S_DIVIDE for the bit-serial remainder unit that finds the next boundary,
// plus state S_REPORT for the report when the window had begun. A table write passes
// through S_WRITE; a table clear sweeps the table in S_CLEAR, one entry per cycle.
// After reset the same pass clears all NUM_DEVICES * NUM_IFACES entries, 16384 at
// the defaults, with in_ready low; configuration writes are accepted throughout.
// The result register lets the next item be accepted while a result waits; when the
// receiver stalls, the block holds the pending result and stops before loading the
// next one. Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and should be written only while the block is idle.
module flow_border_tagger
    import fbt_pkg::*;
#(
    parameter int unsigned NUM_DEVICES = NUM_DEVICES_DEF,
    parameter int unsigned NUM_IFACES  = NUM_IFACES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [DEV_W-1:0]   device_id,
    input  logic [IF_W-1:0]    in_interface,
    input  logic [IF_W-1:0]    out_interface,
    input  logic [TIME_W-1:0]  start_time_s,
    input  logic               entry_is_border,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [1:0]         border_tag,
    output logic               keep_flow,
    output logic [TIME_W-1:0]  window_start_s,
    output logic [TIME_W-1:0]  window_length_s,
    output logic [COUNT_W-1:0] flow_total,
    output logic [COUNT_W-1:0] other_total,
    output logic [COUNT_W-1:0] border_in_total,
    output logic [COUNT_W-1:0] border_out_total,
    output logic               last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Registers are plain flip-flops, so a write can land in any cycle.
    assign cfg_ready = 1'b1;

    fbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fbt_dp #(
        .NUM_DEVICES (NUM_DEVICES),
        .NUM_IFACES  (NUM_IFACES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .device_id        (device_id),
        .in_interface     (in_interface),
        .out_interface    (out_interface),
        .start_time_s     (start_time_s),
        .entry_is_border  (entry_is_border),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .border_tag       (border_tag),
        .keep_flow        (keep_flow),
        .window_start_s   (window_start_s),
        .window_length_s  (window_length_s),
        .flow_total       (flow_total),
        .other_total      (other_total),
        .border_in_total  (border_in_total),
        .border_out_total (border_out_total),
        .last             (last),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

>>> hdl/fbt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fbt_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fbt_rem.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module fbt_rem
    import fbt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              busy,
    output logic [TIME_W-1:0] remainder
);

    localparam int unsigned STEP_W = $clog2(TIME_W);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TIME_W-1:0] dvd_reg, dvd_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W:0]   trial;

    // The partial remainder stays below the divisor, so one extra bit holds the trial.
    assign trial = {rem_reg, dvd_reg[TIME_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[TIME_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = TIME_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[TIME_W-1:0];
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/fbt_ctrl.sv
// Controller state machine of the flow border tagger.
module fbt_ctrl
    import fbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CLEAR    = 9'b000000010,
        S_WRITE    = 9'b000000100,
        S_LOOK_IN  = 9'b000001000,
        S_LOOK_OUT = 9'b000010000,
        S_CHECK    = 9'b000100000,
        S_DIVIDE   = 9'b001000000,
        S_REPORT   = 9'b010000000,
        S_FLOW     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_item = 1'b1;
                    case (opcode_t'(opcode))
                        OP_FLOW:  state_next = S_LOOK_IN;
                        OP_WRITE: state_next = S_WRITE;
                        OP_CLEAR: state_next = S_CLEAR;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRITE:
            begin
                cmd.tbl_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_LOOK_IN:
            begin
                state_next = S_LOOK_OUT;
            end
            S_LOOK_OUT:
            begin
                cmd.rd_out      = 1'b1;
                cmd.cap_in_mark = 1'b1;
                state_next      = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.cap_out_mark = 1'b1;
                if (status.roll_due)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else
                begin
                    state_next = S_FLOW;
                end
            end
            S_DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    if (status.window_begun)
                    begin
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        cmd.win_restart = 1'b1;
                        state_next      = S_FLOW;
                    end
                end
            end
            S_REPORT:
            begin
                if (status.out_free)
                begin
                    cmd.load_report = 1'b1;
                    cmd.win_restart = 1'b1;
                    state_next      = S_FLOW;
                end
            end
            S_FLOW:
            begin
                if (status.out_free)
                begin
                    cmd.load_flow = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The table is swept clear after reset before the first item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_report && cmd.load_flow))
        else $error("report and flow result loaded in the same cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_report || cmd.load_flow) |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> status.div_busy)
        else $error("remainder unit did not start");

endmodule

>>> hdl/fbt_dp.sv
// Datapath of the flow border tagger: table, window state, counters and result register.
module fbt_dp
    import fbt_pkg::*;
#(
    parameter int unsigned NUM_DEVICES = NUM_DEVICES_DEF,
    parameter int unsigned NUM_IFACES  = NUM_IFACES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [DEV_W-1:0]   device_id,
    input  logic [IF_W-1:0]    in_interface,
    input  logic [IF_W-1:0]    out_interface,
    input  logic [TIME_W-1:0]  start_time_s,
    input  logic               entry_is_border,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [1:0]         border_tag,
    output logic               keep_flow,
    output logic [TIME_W-1:0]  window_start_s,
    output logic [TIME_W-1:0]  window_length_s,
    output logic [COUNT_W-1:0] flow_total,
    output logic [COUNT_W-1:0] other_total,
    output logic [COUNT_W-1:0] border_in_total,
    output logic [COUNT_W-1:0] border_out_total,
    output logic               last,
    input  dp_cmd_t            cmd,
    output dp_status_t         status
);

    localparam int unsigned TBL_DEPTH = NUM_DEVICES * NUM_IFACES;
    localparam int unsigned ADDR_W    = $clog2(TBL_DEPTH);

    // Configuration registers.
    logic              drop_reg;
    logic [TIME_W-1:0] interval_reg;
    logic [TIME_W-1:0] iv_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg     <= 1'b0;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DROP_UNKNOWN: drop_reg     <= cfg_data[0];
                CFG_INTERVAL:     interval_reg <= cfg_data;
                default:          drop_reg     <= drop_reg;
            endcase
        end
    end

    assign iv_eff = (interval_reg == '0) ? TIME_W'(1) : interval_reg;

    // Item capture: table addresses and range checks are formed at accept.
    logic [ADDR_W-1:0] addr_in_c, addr_out_c;
    logic              in_ok_c, out_ok_c;
    logic [ADDR_W-1:0] addr_in_reg, addr_out_reg;
    logic              in_ok_reg, out_ok_reg;
    logic [TIME_W-1:0] now_reg;
    logic              entry_reg;

    assign addr_in_c  = ADDR_W'(32'(device_id) * 32'(NUM_IFACES) + 32'(in_interface));
    assign addr_out_c = ADDR_W'(32'(device_id) * 32'(NUM_IFACES) + 32'(out_interface));
    assign in_ok_c    = (32'(device_id) < 32'(NUM_DEVICES))
                        && (32'(in_interface) < 32'(NUM_IFACES));
    assign out_ok_c   = (32'(device_id) < 32'(NUM_DEVICES))
                        && (32'(out_interface) < 32'(NUM_IFACES));

    always_ff @(posedge clk)
    begin
        if (cmd.cap_item)
        begin
            addr_in_reg  <= addr_in_c;
            addr_out_reg <= addr_out_c;
            in_ok_reg    <= in_ok_c;
            out_ok_reg   <= out_ok_c;
            now_reg      <= start_time_s;
            entry_reg    <= entry_is_border;
        end
    end

    // Border mark table with its clearing sweep.
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_last;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic              ram_wdata, ram_rdata;
    logic              mark_in_reg, mark_out_reg;

    assign clr_last      = (clr_addr_reg == ADDR_W'(TBL_DEPTH - 1));
    assign clr_addr_next = clr_last ? '0 : clr_addr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_write)
        begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign ram_we    = cmd.clr_write || (cmd.tbl_write && in_ok_reg);
    assign ram_waddr = cmd.clr_write ? clr_addr_reg : addr_in_reg;
    assign ram_wdata = cmd.clr_write ? 1'b0 : entry_reg;
    assign ram_raddr = cmd.rd_out ? addr_out_reg : addr_in_reg;

    fbt_ram #(
        .WIDTH (1),
        .DEPTH (TBL_DEPTH)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in_mark)
        begin
            mark_in_reg <= ram_rdata && in_ok_reg;
        end
        if (cmd.cap_out_mark)
        begin
            mark_out_reg <= ram_rdata && out_ok_reg;
        end
    end

    // Next boundary: the multiple of the interval above the flow time, from the remainder.
    logic              div_busy;
    logic [TIME_W-1:0] rem;
    logic [TIME_W:0]   nb_sum;
    logic [TIME_W-1:0] nb;

    fbt_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (now_reg),
        .divisor   (iv_eff),
        .busy      (div_busy),
        .remainder (rem)
    );

    assign nb_sum = {1'b0, now_reg - rem} + {1'b0, iv_eff};
    assign nb     = nb_sum[TIME_W] ? TIME_MAX : nb_sum[TIME_W-1:0];

    // Window state and counters.
    logic [TIME_W-1:0]  window_begin_reg, next_boundary_reg;
    logic [COUNT_W-1:0] cnt_flows_reg, cnt_other_reg, cnt_in_reg, cnt_out_reg;
    tag_t               tag;
    logic               keep;

    always_comb
    begin
        if (mark_in_reg)
        begin
            tag = TAG_IN;
        end
        else if (mark_out_reg)
        begin
            tag = TAG_OUT;
        end
        else
        begin
            tag = TAG_UNKNOWN;
        end
    end

    assign keep = (tag != TAG_UNKNOWN) || !drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_begin_reg  <= '0;
            next_boundary_reg <= '0;
            cnt_flows_reg     <= '0;
            cnt_other_reg     <= '0;
            cnt_in_reg        <= '0;
            cnt_out_reg       <= '0;
        end
        else if (cmd.win_restart)
        begin
            window_begin_reg  <= now_reg;
            next_boundary_reg <= nb;
            cnt_flows_reg     <= '0;
            cnt_other_reg     <= '0;
            cnt_in_reg        <= '0;
            cnt_out_reg       <= '0;
        end
        else if (cmd.load_flow)
        begin
            cnt_flows_reg <= sat_inc(cnt_flows_reg);
            case (tag)
                TAG_IN:  cnt_in_reg    <= sat_inc(cnt_in_reg);
                TAG_OUT: cnt_out_reg   <= sat_inc(cnt_out_reg);
                default: cnt_other_reg <= sat_inc(cnt_other_reg);
            endcase
        end
    end

    // Output register.
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_report || cmd.load_flow)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_report)
        begin
            kind             <= KIND_REPORT;
            border_tag       <= TAG_UNKNOWN;
            keep_flow        <= 1'b0;
            window_start_s   <= window_begin_reg;
            window_length_s  <= now_reg - window_begin_reg;
            flow_total       <= cnt_flows_reg;
            other_total      <= cnt_other_reg;
            border_in_total  <= cnt_in_reg;
            border_out_total <= cnt_out_reg;
            last             <= 1'b0;
        end
        else if (cmd.load_flow)
        begin
            kind             <= KIND_FLOW;
            border_tag       <= tag;
            keep_flow        <= keep;
            window_start_s   <= '0;
            window_length_s  <= '0;
            flow_total       <= '0;
            other_total      <= '0;
            border_in_total  <= '0;
            border_out_total <= '0;
            last             <= 1'b1;
        end
    end

    assign out_valid           = out_valid_reg;
    assign status.roll_due     = now_reg > next_boundary_reg;
    assign status.window_begun = window_begin_reg != '0;
    assign status.div_busy     = div_busy;
    assign status.clr_last     = clr_last;
    assign status.out_free     = !out_valid_reg || out_ready;

    a_report_begun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_report |-> (window_begin_reg != '0))
        else $error("report of a window that never began");

    a_boundary_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.win_restart |=> (next_boundary_reg >= window_begin_reg))
        else $error("next boundary lies before the window start");

endmodule
